// ===== design/apsp_pkg.sv =====
// Shared constants, codes and request/response types of the all-pairs shortest path block.
package apsp_pkg;

   localparam int MAX_VERTICES  = 16;
   localparam int WEIGHT_BITS   = 16;
   localparam int DISTANCE_BITS = 24;

   localparam int VERTEX_W = $clog2(MAX_VERTICES + 1);
   localparam int WEIGHT_W = WEIGHT_BITS;
   localparam int DIST_W   = DISTANCE_BITS;
   localparam int CSR_W    = VERTEX_W;

   localparam logic [VERTEX_W-1:0] COUNT_RESET = VERTEX_W'(MAX_VERTICES);

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_RUN   = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      CSR_VERTEX_COUNT = 1'd0,
      CSR_UNDIRECTED   = 1'd1
   } csr_index_type;

   typedef struct packed {
      mode_type              mode;
      logic [VERTEX_W-1:0]   from_vertex;
      logic [VERTEX_W-1:0]   to_vertex;
      logic [WEIGHT_W-1:0]   weight;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [DIST_W-1:0]     distance;
      logic [VERTEX_W-1:0]   next_vertex;
   } rsp_type;

endpackage

// ===== design/apsp_adj_ram.sv =====
// Adjacency store: single write port, single registered read port.
module apsp_adj_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== design/apsp_dist_ram.sv =====
// Distance and next-hop store: single write port, two registered read ports.
module apsp_dist_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 28
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule

// ===== design/apsp_relax.sv =====
// Relaxation step: saturating path sum through the intermediate vertex and compare.
module apsp_relax #(
   parameter int DISTANCE_BITS = 24,
   parameter int HOP_BITS      = 4
) (
   input  logic [DISTANCE_BITS-1:0] left_dist,
   input  logic [DISTANCE_BITS-1:0] right_dist,
   input  logic [DISTANCE_BITS-1:0] cur_dist,
   input  logic [HOP_BITS-1:0]      left_hop,
   output logic                     update,
   output logic [DISTANCE_BITS-1:0] new_dist,
   output logic [HOP_BITS-1:0]      new_hop
);

   localparam logic [DISTANCE_BITS-1:0] DIST_NONE = '1;
   localparam logic [DISTANCE_BITS-1:0] DIST_TOP  = DIST_NONE - 1'b1;

   logic [DISTANCE_BITS:0] sum;

   always_comb begin
      sum = {1'b0, left_dist} + {1'b0, right_dist};
      if (left_dist == DIST_NONE || right_dist == DIST_NONE) begin
         new_dist = DIST_NONE;
      end else if (sum > {1'b0, DIST_TOP}) begin
         new_dist = DIST_TOP;
      end else begin
         new_dist = sum[DISTANCE_BITS-1:0];
      end
      update  = cur_dist > new_dist;
      new_hop = left_hop;
   end

endmodule

// ===== design/all_pairs_shortest_path.sv =====
// Top level: request sequencer, stores and response register of the shortest path block.
// Sequence: an edge write or a rejected request loads the response register as it is taken;
//   an undirected write adds a busy mirror state; a query answers from a registered read;
//   clear sweeps every cell; run copies, then relaxes, the cells of the n active vertices.
// Throughput: one request at a time; the run is bound by the distance store's ports,
//   one relaxation per cycle plus one row-pivot read per row.
// Reset: synchronous; a clearing pass over all MAX_VERTICES^2 cells (256 by default) fills
//   both stores, with req_ready low until it ends. Configuration writes are taken throughout.
module all_pairs_shortest_path #(
   parameter int MAX_VERTICES  = apsp_pkg::MAX_VERTICES,
   parameter int WEIGHT_BITS   = apsp_pkg::WEIGHT_BITS,
   parameter int DISTANCE_BITS = apsp_pkg::DISTANCE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  apsp_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output apsp_pkg::rsp_type           rsp_data,
   input  logic                        csr_write,
   input  logic [0:0]                  csr_index,
   input  logic [apsp_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int VB    = $clog2(MAX_VERTICES);
   localparam int NB    = $clog2(MAX_VERTICES + 1);
   localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(CELLS);
   localparam int AB    = WEIGHT_BITS + 1;
   localparam int DB    = DISTANCE_BITS;
   localparam int HB    = DB + VB;
   localparam int CW    = (AB > DB) ? AB : DB;

   localparam logic [AB-1:0] ADJ_NONE  = AB'(1) << WEIGHT_BITS;
   localparam logic [DB-1:0] DIST_NONE = '1;
   localparam logic [DB-1:0] DIST_TOP  = DIST_NONE - 1'b1;
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_MIRROR, S_QUERY, S_CLEAR,
      S_COPY, S_SETTLE, S_ROW, S_COL, S_DRAIN
   } state_type;

   function automatic logic [AW-1:0] cell_addr(input logic [VB-1:0] row,
                                               input logic [VB-1:0] col);
      return AW'(AW'(row) * AW'(MAX_VERTICES) + AW'(col));
   endfunction

   state_type                      state_ff, state_in;
   logic [AW-1:0]                  sweep_ff, sweep_in;
   logic [VB-1:0]                  r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [VB-1:0]                  mf_ff, mf_in, mt_ff, mt_in;
   logic [AB-1:0]                  wt_ff, wt_in;
   logic                           copy_vld_ff, copy_vld_in;
   logic [AW-1:0]                  copy_addr_ff, copy_addr_in;
   logic [VB-1:0]                  copy_col_ff, copy_col_in;
   logic                           row_rd_ff, row_rd_in;
   logic                           pipe_vld_ff, pipe_vld_in;
   logic [VB-1:0]                  pipe_row_ff, pipe_row_in, pipe_col_ff, pipe_col_in;
   logic [VB-1:0]                  pipe_k_ff, pipe_k_in;
   logic [DB-1:0]                  left_ff, left_in;
   logic [VB-1:0]                  hop_left_ff, hop_left_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   apsp_pkg::rsp_type              rsp_ff, rsp_in;
   logic [apsp_pkg::VERTEX_W-1:0]  vc_ff, vc_in;
   logic                           und_ff, und_in;

   logic                           rsp_load;
   logic [NB-1:0]                  n_act;
   logic                           from_ok, to_ok, weight_ok;
   logic [VB-1:0]                  fi, ti;

   logic                           adj_we;
   logic [AW-1:0]                  adj_waddr, adj_raddr;
   logic [AB-1:0]                  adj_wdata, adj_rdata;
   logic                           dist_we;
   logic [AW-1:0]                  dist_waddr, dist_raddr0, dist_raddr1;
   logic [HB-1:0]                  dist_wdata, dist_rd0, dist_rd1;

   logic [CW-1:0]                  adj_ext;
   logic [DB-1:0]                  copy_dist;
   logic                           relax_update;
   logic [DB-1:0]                  relax_dist;
   logic [VB-1:0]                  relax_hop;

   apsp_adj_ram #(.DEPTH(CELLS), .WIDTH(AB)) u_adj_ram (
      .clock (clock),
      .we    (adj_we),
      .waddr (adj_waddr),
      .wdata (adj_wdata),
      .raddr (adj_raddr),
      .rdata (adj_rdata)
   );

   apsp_dist_ram #(.DEPTH(CELLS), .WIDTH(HB)) u_dist_ram (
      .clock  (clock),
      .we     (dist_we),
      .waddr  (dist_waddr),
      .wdata  (dist_wdata),
      .raddr0 (dist_raddr0),
      .raddr1 (dist_raddr1),
      .rdata0 (dist_rd0),
      .rdata1 (dist_rd1)
   );

   apsp_relax #(.DISTANCE_BITS(DB), .HOP_BITS(VB)) u_relax (
      .left_dist  (left_ff),
      .right_dist (dist_rd0[HB-1:VB]),
      .cur_dist   (dist_rd1[HB-1:VB]),
      .left_hop   (hop_left_ff),
      .update     (relax_update),
      .new_dist   (relax_dist),
      .new_hop    (relax_hop)
   );

   function automatic logic is_last(input logic [VB-1:0] x, input logic [NB-1:0] n);
      return (NB'(x) + NB'(1)) == n;
   endfunction

   always_comb begin
      if (vc_ff == '0) begin
         n_act = NB'(1);
      end else if (32'(vc_ff) > MAX_VERTICES) begin
         n_act = NB'(MAX_VERTICES);
      end else begin
         n_act = NB'(vc_ff);
      end
      from_ok   = (req_data.from_vertex != '0) && (32'(req_data.from_vertex) <= 32'(n_act));
      to_ok     = (req_data.to_vertex != '0) && (32'(req_data.to_vertex) <= 32'(n_act));
      weight_ok = (33'(req_data.weight) >> WEIGHT_BITS) == '0;
      fi        = VB'(req_data.from_vertex - apsp_pkg::VERTEX_W'(1));
      ti        = VB'(req_data.to_vertex - apsp_pkg::VERTEX_W'(1));
   end

   // copy of an adjacency entry into the distance store
   always_comb begin
      adj_ext = CW'(adj_rdata);
      if (adj_rdata == ADJ_NONE) begin
         copy_dist = DIST_NONE;
      end else if (adj_ext > CW'(DIST_TOP)) begin
         copy_dist = DIST_TOP;
      end else begin
         copy_dist = DB'(adj_ext);
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      mf_in        = mf_ff;
      mt_in        = mt_ff;
      wt_in        = wt_ff;
      copy_vld_in  = 1'b0;
      copy_addr_in = cell_addr(r_ff, c_ff);
      copy_col_in  = c_ff;
      row_rd_in    = 1'b0;
      pipe_vld_in  = 1'b0;
      pipe_row_in  = r_ff;
      pipe_col_in  = c_ff;
      pipe_k_in    = k_ff;
      left_in      = row_rd_ff ? dist_rd0[HB-1:VB] : left_ff;
      hop_left_in  = row_rd_ff ? dist_rd0[VB-1:0] : hop_left_ff;
      adj_we       = 1'b0;
      adj_waddr    = sweep_ff;
      adj_wdata    = ADJ_NONE;
      adj_raddr    = cell_addr(r_ff, c_ff);
      dist_raddr0  = cell_addr(k_ff, c_ff);
      dist_raddr1  = cell_addr(r_ff, c_ff);
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      rsp_in       = '0;

      unique case (state_ff)
         S_INIT: begin
            adj_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               unique case (req_data.mode)
                  apsp_pkg::MODE_WRITE: begin
                     rsp_load      = 1'b1;
                     rsp_in.status = !(from_ok && to_ok && weight_ok);
                     if (from_ok && to_ok && weight_ok) begin
                        adj_we    = 1'b1;
                        adj_waddr = cell_addr(fi, ti);
                        adj_wdata = AB'(req_data.weight);
                        mf_in     = fi;
                        mt_in     = ti;
                        wt_in     = AB'(req_data.weight);
                        if (und_ff) begin
                           state_in = S_MIRROR;
                        end
                     end
                  end
                  apsp_pkg::MODE_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end
                  apsp_pkg::MODE_RUN: begin
                     r_in     = '0;
                     c_in     = '0;
                     state_in = S_COPY;
                  end
                  apsp_pkg::MODE_QUERY: begin
                     dist_raddr1 = cell_addr(fi, ti);
                     if (from_ok && to_ok) begin
                        state_in = S_QUERY;
                     end else begin
                        rsp_load      = 1'b1;
                        rsp_in.status = 1'b1;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MIRROR: begin
            adj_we    = 1'b1;
            adj_waddr = cell_addr(mt_ff, mf_ff);
            adj_wdata = wt_ff;
            state_in  = S_IDLE;
         end
         S_QUERY: begin
            rsp_load           = 1'b1;
            rsp_in.distance    = apsp_pkg::DIST_W'(dist_rd1[HB-1:VB]);
            rsp_in.next_vertex = apsp_pkg::VERTEX_W'(dist_rd1[VB-1:0]) +
                                 apsp_pkg::VERTEX_W'(1);
            state_in           = S_IDLE;
         end
         S_CLEAR: begin
            adj_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_COPY: begin
            copy_vld_in = 1'b1;
            if (is_last(c_ff, n_act)) begin
               c_in = '0;
               if (is_last(r_ff, n_act)) begin
                  state_in = S_SETTLE;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         S_SETTLE: begin
            r_in     = '0;
            c_in     = '0;
            k_in     = '0;
            state_in = S_ROW;
         end
         S_ROW: begin
            dist_raddr0 = cell_addr(r_ff, k_ff);
            row_rd_in   = 1'b1;
            c_in        = '0;
            state_in    = S_COL;
         end
         S_COL: begin
            pipe_vld_in = 1'b1;
            if (is_last(c_ff, n_act)) begin
               if (is_last(r_ff, n_act)) begin
                  if (is_last(k_ff, n_act)) begin
                     state_in = S_DRAIN;
                  end else begin
                     k_in     = k_ff + 1'b1;
                     r_in     = '0;
                     state_in = S_ROW;
                  end
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = S_ROW;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // distance store write: reset fill, copy pipe, relaxation pipe
   always_comb begin
      dist_we    = 1'b0;
      dist_waddr = sweep_ff;
      dist_wdata = {DIST_NONE, {VB{1'b0}}};
      priority if (state_ff == S_INIT) begin
         dist_we = 1'b1;
      end else if (copy_vld_ff) begin
         dist_we    = 1'b1;
         dist_waddr = copy_addr_ff;
         dist_wdata = {copy_dist, copy_col_ff};
      end else if (pipe_vld_ff && relax_update) begin
         dist_we    = 1'b1;
         dist_waddr = cell_addr(pipe_row_ff, pipe_col_ff);
         dist_wdata = {relax_dist, relax_hop};
      end
   end

   always_comb begin
      vc_in  = vc_ff;
      und_in = und_ff;
      if (csr_write) begin
         unique case (apsp_pkg::csr_index_type'(csr_index))
            apsp_pkg::CSR_VERTEX_COUNT: vc_in  = csr_wdata;
            apsp_pkg::CSR_UNDIRECTED:   und_in = csr_wdata[0];
            default:                    vc_in  = vc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         copy_vld_ff  <= 1'b0;
         row_rd_ff    <= 1'b0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vc_ff        <= apsp_pkg::COUNT_RESET;
         und_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         copy_vld_ff  <= copy_vld_in;
         row_rd_ff    <= row_rd_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         vc_ff        <= vc_in;
         und_ff       <= und_in;
      end
      r_ff         <= r_in;
      c_ff         <= c_in;
      k_ff         <= k_in;
      mf_ff        <= mf_in;
      mt_ff        <= mt_in;
      wt_ff        <= wt_in;
      copy_addr_ff <= copy_addr_in;
      copy_col_ff  <= copy_col_in;
      pipe_row_ff  <= pipe_row_in;
      pipe_col_ff  <= pipe_col_in;
      pipe_k_ff    <= pipe_k_in;
      left_ff      <= left_in;
      hop_left_ff  <= hop_left_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over an untaken response");

   a_pivot_untouched: assert property (@(posedge clock) disable iff (reset)
      (pipe_vld_ff && relax_update) |-> (pipe_row_ff != pipe_k_ff && pipe_col_ff != pipe_k_ff))
      else $error("relaxation wrote the pivot row or column");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(copy_vld_ff && pipe_vld_ff))
      else $error("copy and relaxation writes overlap");

   a_no_request_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> (!req_ready && !rsp_load))
      else $error("request taken during clearing pass");

endmodule

// ===== verif/apsp_route_checker.sv =====
// Checker for the shortest path block: tracks registers, predicts responses and compares them.
`timescale 1ns / 100ps
module apsp_route_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  apsp_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  apsp_pkg::rsp_type           rsp_data,
   input  logic                        csr_write,
   input  logic [0:0]                  csr_index,
   input  logic [apsp_pkg::CSR_W-1:0]  csr_wdata,
   output int unsigned                 open_answers,
   output int unsigned                 fail_count
);

   localparam int CELLS  = apsp_pkg::MAX_VERTICES * apsp_pkg::MAX_VERTICES;
   localparam int HOP_W  = $clog2(apsp_pkg::MAX_VERTICES);
   localparam int WIDE_W = apsp_pkg::DIST_W + 1;
   localparam logic [apsp_pkg::WEIGHT_W:0] NO_LINK  = {1'b1, {apsp_pkg::WEIGHT_W{1'b0}}};
   localparam logic [apsp_pkg::DIST_W-1:0] NO_PATH  = '1;
   localparam logic [apsp_pkg::DIST_W-1:0] TOP_PATH = NO_PATH - 1'b1;

   logic [apsp_pkg::WEIGHT_W:0]   link_weight [CELLS];
   logic [apsp_pkg::DIST_W-1:0]   path_len [CELLS];
   logic [HOP_W-1:0]              first_hop [CELLS];
   logic [apsp_pkg::VERTEX_W-1:0] vertex_limit;
   logic                          two_way;
   apsp_pkg::rsp_type             route_answers [$];
   int unsigned                   mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: response mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
   endtask

   function automatic int unsigned live_vertices();
      if (vertex_limit == 0) return 1;
      if (vertex_limit > apsp_pkg::MAX_VERTICES) return apsp_pkg::MAX_VERTICES;
      return vertex_limit;
   endfunction

   function automatic bit in_range(int unsigned v, int unsigned n);
      return v >= 1 && v <= n;
   endfunction

   function automatic void restore_reset();
      for (int i = 0; i < CELLS; i++) begin
         link_weight[i] = NO_LINK;
         path_len[i] = NO_PATH;
         first_hop[i] = '0;
      end
      vertex_limit = apsp_pkg::COUNT_RESET;
      two_way = 1'b0;
   endfunction

   function automatic void relax_all(int unsigned n);
      logic [WIDE_W-1:0] wide;
      logic [WIDE_W-1:0] via;
      int unsigned       rc;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            rc = r * apsp_pkg::MAX_VERTICES + c;
            wide = WIDE_W'(link_weight[rc]);
            if (link_weight[rc] == NO_LINK) path_len[rc] = NO_PATH;
            else path_len[rc] = (wide > TOP_PATH) ? TOP_PATH : wide[apsp_pkg::DIST_W-1:0];
            first_hop[rc] = HOP_W'(c);
         end
      end
      for (int k = 0; k < n; k++) begin
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               rc = r * apsp_pkg::MAX_VERTICES + c;
               if (path_len[r*apsp_pkg::MAX_VERTICES+k] == NO_PATH ||
                   path_len[k*apsp_pkg::MAX_VERTICES+c] == NO_PATH) begin
                  via = {1'b0, NO_PATH};
               end else begin
                  via = WIDE_W'(path_len[r*apsp_pkg::MAX_VERTICES+k]) +
                        WIDE_W'(path_len[k*apsp_pkg::MAX_VERTICES+c]);
                  if (via > TOP_PATH) via = WIDE_W'(TOP_PATH);
               end
               if (path_len[rc] > via) begin
                  path_len[rc] = via[apsp_pkg::DIST_W-1:0];
                  first_hop[rc] = first_hop[r*apsp_pkg::MAX_VERTICES+k];
               end
            end
         end
      end
   endfunction

   function automatic apsp_pkg::rsp_type route_request(apsp_pkg::req_type r);
      apsp_pkg::rsp_type answer;
      int unsigned       n;
      int unsigned       src;
      int unsigned       dst;
      answer = '0;
      n = live_vertices();
      src = r.from_vertex;
      dst = r.to_vertex;
      case (r.mode)
         apsp_pkg::MODE_WRITE: begin
            if (!in_range(src, n) || !in_range(dst, n)) begin
               answer.status = 1'b1;
            end else begin
               link_weight[(src-1)*apsp_pkg::MAX_VERTICES + dst-1] = {1'b0, r.weight};
               if (two_way)
                  link_weight[(dst-1)*apsp_pkg::MAX_VERTICES + src-1] = {1'b0, r.weight};
            end
         end
         apsp_pkg::MODE_CLEAR: begin
            for (int i = 0; i < CELLS; i++) link_weight[i] = NO_LINK;
         end
         apsp_pkg::MODE_RUN: begin
            relax_all(n);
         end
         default: begin
            if (!in_range(src, n) || !in_range(dst, n)) begin
               answer.status = 1'b1;
            end else begin
               answer.distance = path_len[(src-1)*apsp_pkg::MAX_VERTICES + dst-1];
               answer.next_vertex =
                  apsp_pkg::VERTEX_W'(first_hop[(src-1)*apsp_pkg::MAX_VERTICES + dst-1]) +
                  apsp_pkg::VERTEX_W'(1);
            end
         end
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin
      apsp_pkg::rsp_type want;
      if (reset) begin
         restore_reset();
         route_answers.delete();
         open_answers <= 0;
      end else begin
         if (req_valid && req_ready) route_answers.push_back(route_request(req_data));
         if (csr_write) begin
            if (csr_index == apsp_pkg::CSR_VERTEX_COUNT) vertex_limit = csr_wdata;
            else two_way = csr_wdata[0];
         end
         if (rsp_valid && rsp_ready) begin
            if (route_answers.size() == 0) begin
               report_mismatch("unrequested response", 0, 1);
            end else begin
               want = route_answers.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_data.status));
               if (rsp_data.distance !== want.distance)
                  report_mismatch("distance", 32'(want.distance), 32'(rsp_data.distance));
               if (rsp_data.next_vertex !== want.next_vertex)
                  report_mismatch("next_vertex", 32'(want.next_vertex),
                                  32'(rsp_data.next_vertex));
            end
         end
         open_answers <= route_answers.size();
      end
   end

endmodule

// ===== verif/all_pairs_shortest_path_tb.sv =====
// Testbench top: clock, reset, request and register stimulus, response pacing and verdict.
`timescale 1ns / 100ps
module all_pairs_shortest_path_tb;

   localparam int QUIET_LIMIT = 30000;
   localparam int HOLD_CYCLES = 300;
   localparam int REQUEST_GOAL = 1000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   apsp_pkg::req_type              req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   apsp_pkg::rsp_type              rsp_data;
   logic                           csr_write;
   logic [0:0]                     csr_index;
   logic [apsp_pkg::CSR_W-1:0]     csr_wdata;
   int unsigned                    open_answers;
   int unsigned                    fail_count;

   bit                   idle_on;
   bit                   hold_request;
   int unsigned          quiet;
   int unsigned          sent;
   int unsigned          phases;
   int unsigned          runs;
   int unsigned          queries;

   all_pairs_shortest_path dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   apsp_route_checker route_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .open_answers(open_answers), .fail_count(fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side: random hold-off per response while idle gaps are on, one long hold on request
   initial begin
      int unsigned gap;
      bit          held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            gap = HOLD_CYCLES;
         end else begin
            gap = idle_on ? $urandom_range(0, 12) : 0;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_request(input apsp_pkg::mode_type m,
                               input logic [apsp_pkg::VERTEX_W-1:0] src,
                               input logic [apsp_pkg::VERTEX_W-1:0] dst,
                               input logic [apsp_pkg::WEIGHT_W-1:0] w);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: m, from_vertex: src, to_vertex: dst, weight: w};
      do @(posedge clock); while (!req_ready);
      sent++;
      if (m == apsp_pkg::MODE_RUN) runs++;
      if (m == apsp_pkg::MODE_QUERY) queries++;
   endtask

   // drop valid and wait until every response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_answers != 0) @(posedge clock);
   endtask

   task automatic write_csr(input apsp_pkg::csr_index_type idx,
                            input logic [apsp_pkg::CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int unsigned live_count(logic [apsp_pkg::CSR_W-1:0] c);
      if (c == 0) return 1;
      if (c > apsp_pkg::MAX_VERTICES) return apsp_pkg::MAX_VERTICES;
      return c;
   endfunction

   function automatic logic [apsp_pkg::VERTEX_W-1:0] pick_vertex(int unsigned n);
      case ($urandom_range(0, 15))
         0: return '0;
         1: return apsp_pkg::VERTEX_W'(n + 1);
         2: return apsp_pkg::VERTEX_W'($urandom_range(0, 31));
         default: return apsp_pkg::VERTEX_W'($urandom_range(1, n));
      endcase
   endfunction

   function automatic logic [apsp_pkg::WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return apsp_pkg::WEIGHT_W'($urandom_range(0, 15));
         4, 5: return apsp_pkg::WEIGHT_W'($urandom);
         default: return apsp_pkg::WEIGHT_W'($urandom_range(1, 1000));
      endcase
   endfunction

   initial begin
      logic [apsp_pkg::CSR_W-1:0] count;
      int unsigned                n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      idle_on = 1'b0;
      hold_request = 1'b0;
      sent = 0;
      phases = 0;
      runs = 0;
      queries = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, rejects, extreme weights, self edge, stale reads
      send_request(apsp_pkg::MODE_QUERY, 5'd1, 5'd1, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd0, 5'd1, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd16, 5'd16, '1);
      send_request(apsp_pkg::MODE_WRITE, 5'd1, 5'd2, '0);
      send_request(apsp_pkg::MODE_WRITE, 5'd2, 5'd3, '1);
      send_request(apsp_pkg::MODE_WRITE, 5'd3, 5'd4, 16'd1);
      send_request(apsp_pkg::MODE_WRITE, 5'd1, 5'd4, '1);
      send_request(apsp_pkg::MODE_WRITE, 5'd16, 5'd16, 16'd5);
      send_request(apsp_pkg::MODE_WRITE, 5'd0, 5'd5, 16'd1);
      send_request(apsp_pkg::MODE_WRITE, 5'd5, 5'd17, 16'd1);
      send_request(apsp_pkg::MODE_WRITE, 5'd31, 5'd1, 16'd3);
      send_request(apsp_pkg::MODE_RUN, '0, '0, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd1, 5'd4, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd1, 5'd1, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd16, 5'd16, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd4, 5'd1, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd2, 5'd31, '0);
      send_request(apsp_pkg::MODE_CLEAR, '1, '1, '1);
      send_request(apsp_pkg::MODE_QUERY, 5'd1, 5'd4, '0);
      send_request(apsp_pkg::MODE_RUN, '0, '0, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd1, 5'd4, '0);
      settle();
      write_csr(apsp_pkg::CSR_VERTEX_COUNT, 5'd0);
      write_csr(apsp_pkg::CSR_UNDIRECTED, 5'd1);
      send_request(apsp_pkg::MODE_WRITE, 5'd1, 5'd1, 16'd7);
      send_request(apsp_pkg::MODE_WRITE, 5'd1, 5'd2, 16'd9);
      send_request(apsp_pkg::MODE_RUN, '0, '0, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd1, 5'd1, '0);
      send_request(apsp_pkg::MODE_QUERY, 5'd2, 5'd2, '0);

      while (sent < REQUEST_GOAL) begin
         phases++;
         settle();
         case ($urandom_range(0, 9))
            0: count = 5'd0;
            1: count = 5'd16;
            2: count = apsp_pkg::CSR_W'($urandom_range(17, 31));
            3: count = apsp_pkg::CSR_W'($urandom_range(7, 15));
            default: count = apsp_pkg::CSR_W'($urandom_range(1, 6));
         endcase
         write_csr(apsp_pkg::CSR_VERTEX_COUNT, count);
         write_csr(apsp_pkg::CSR_UNDIRECTED, apsp_pkg::CSR_W'($urandom_range(0, 31)));
         idle_on = ($urandom_range(0, 3) != 0);
         n = live_count(count);
         if ($urandom_range(0, 1) != 0) send_request(apsp_pkg::MODE_CLEAR, pick_vertex(n),
                                                     pick_vertex(n), pick_weight());
         repeat ($urandom_range(1, 3 * n))
            send_request(apsp_pkg::MODE_WRITE, pick_vertex(n), pick_vertex(n), pick_weight());
         if ($urandom_range(0, 7) != 0) send_request(apsp_pkg::MODE_RUN, '0, '0, '0);
         if (phases == 3) hold_request = 1'b1;
         repeat (phases == 3 ? 40 : $urandom_range(2, 2 * n + 4))
            send_request(apsp_pkg::MODE_QUERY, pick_vertex(n), pick_vertex(n), pick_weight());
         repeat ($urandom_range(0, 2))
            send_request(apsp_pkg::mode_type'($urandom_range(0, 3)),
                         apsp_pkg::VERTEX_W'($urandom), apsp_pkg::VERTEX_W'($urandom),
                         apsp_pkg::WEIGHT_W'($urandom));
      end

      settle();
      repeat (20) @(posedge clock);
      $display("%0d requests in %0d register settings, %0d runs and %0d queries",
               sent, phases, runs, queries);
      $display("vertex counts 0 to 31, both edge directions, one long response hold");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
